// ----- sv/plu_pkg.sv -----
// Shared types and constants for the piecewise-linear lookup block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package plu_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Register byte addresses on the configuration port.
  localparam logic [3:0] ADDR_LEFT_SLOPE  = 4'h0;
  localparam logic [3:0] ADDR_RIGHT_SLOPE = 4'h4;
  localparam logic [3:0] ADDR_NODE_COUNT  = 4'h8;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_MID   = 2'd1,
    REG_RIGHT = 2'd2
  } region_t;

  typedef struct packed {
    logic    wr;
    logic    start;
    logic    next;
    logic    setup;
    region_t mode;
    logic    mul_step;
    logic    div_start;
    logic    div_step;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic first;
    logic last;
    logic mul_done;
    logic div_done;
    logic interp;
    logic out_busy;
  } status_t;

endpackage

// ----- sv/plu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module plu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/plu_ctrl.sv -----
// Sequencing state machine for the lookup block: scan, multiply, divide, finish.
// Depends on plu_pkg for the command and status structs.
`timescale 1ns / 1ps
module plu_ctrl
  import plu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_action,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mode   = REG_LEFT;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_LOOKUP) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (st.hit) begin
          cmd.setup  = 1'b1;
          cmd.mode   = st.first ? REG_LEFT : REG_MID;
          state_next = ST_MUL;
        end else if (st.last) begin
          cmd.setup  = 1'b1;
          cmd.mode   = REG_RIGHT;
          state_next = ST_MUL;
        end else begin
          cmd.next = 1'b1;
        end
      end
      ST_MUL: begin
        if (st.mul_done) begin
          if (st.interp) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            state_next = ST_FIN;
          end
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (st.div_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/plu_datapath.sv -----
// Datapath: node table, scan compare, serial multiplier, serial divider, result.
// Depends on plu_pkg and plu_ram.
`timescale 1ns / 1ps
module plu_datapath
  import plu_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [3:0]         wr_index,
  input  logic signed [31:0] wr_x,
  input  logic signed [31:0] wr_y,
  input  logic signed [31:0] value_in,
  input  logic signed [31:0] low_slope,
  input  logic signed [31:0] high_slope,
  input  logic [4:0]         node_count,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        value_out,
  output region_t            region,
  output logic               saturated,
  output status_t            st
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int STEPS = 33;
  localparam logic [65:0] RND = (66'd1 << FRAC_BITS) - 66'd1;

  logic [MAX_NODES-1:0] node_valid;
  logic                 wr_en, rd_en, rd_vld;
  logic [IW-1:0]        waddr, raddr, idx, last_idx;
  logic [63:0]          rdata;
  logic [8:0]           widx9, cnt9, eff9;

  logic signed [31:0] v, cur_x, cur_y, prev_x, prev_y, base_y;
  logic [65:0]        mcand, prod;
  logic [32:0]        mplier, dx, rem, dlow, quot;
  logic [5:0]         mcnt, dcnt;
  logic               neg;
  region_t            mode;

  // Write port and per-entry valid bits; an entry not yet written reads as zero.
  assign widx9 = {5'd0, wr_index};
  assign waddr = widx9[IW-1:0];
  assign wr_en = cmd.wr && (widx9 < 9'(MAX_NODES));
  assign rd_en = cmd.start | cmd.next;
  assign raddr = cmd.start ? '0 : idx + IW'(1);

  plu_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata ({wr_y, wr_x}),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= '0;
    end else if (wr_en) begin
      node_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld <= (wr_en && waddr == raddr) ? node_valid[raddr] : node_valid[raddr];
    end
  end

  assign cur_x = rd_vld ? signed'(rdata[31:0])  : 32'sd0;
  assign cur_y = rd_vld ? signed'(rdata[63:32]) : 32'sd0;

  // Index of the last node in use, with a zero count read as one node and a count above MAX_NODES read as MAX_NODES.
  assign cnt9     = {4'd0, node_count};
  assign eff9     = (cnt9 == 9'd0) ? 9'd1 :
                    (cnt9 > 9'(MAX_NODES)) ? 9'(MAX_NODES) : cnt9;
  assign last_idx = IW'(eff9 - 9'd1);

  logic signed [32:0] dv, dy, dsel;
  logic        [32:0] dmag, ymag;
  logic signed [31:0] slope;
  logic        [31:0] smag;

  assign dv    = 33'(v) - 33'(cmd.mode == REG_MID ? prev_x : cur_x);
  assign dy    = 33'(cur_y) - 33'(prev_y);
  assign dsel  = dv;
  assign dmag  = dsel[32] ? 33'(-dsel) : dsel;
  assign ymag  = dy[32] ? 33'(-dy) : dy;
  assign slope = (cmd.mode == REG_RIGHT) ? high_slope : low_slope;
  assign smag  = slope[31] ? 32'(-slope) : slope;

  logic [33:0] dtrial;
  assign dtrial = {rem, dlow[32]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v   <= value_in;
      idx <= '0;
    end
    if (cmd.next) begin
      idx    <= idx + IW'(1);
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (cmd.setup) begin
      mode   <= cmd.mode;
      mcand  <= {33'd0, dmag};
      prod   <= '0;
      mcnt   <= '0;
      dx     <= 33'(cur_x) - 33'(prev_x);
      if (cmd.mode == REG_MID) begin
        mplier <= ymag;
        neg    <= dy[32];
        base_y <= prev_y;
      end else begin
        mplier <= {1'b0, smag};
        neg    <= dsel[32] ^ slope[31];
        base_y <= cur_y;
      end
    end
    if (cmd.mul_step) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      mcnt   <= mcnt + 6'd1;
    end
    if (cmd.div_start) begin
      rem  <= prod[65:33];
      dlow <= prod[32:0];
      quot <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (dtrial >= {1'b0, dx}) begin
        rem  <= 33'(dtrial - {1'b0, dx});
        quot <= {quot[31:0], 1'b1};
      end else begin
        rem  <= dtrial[32:0];
        quot <= {quot[31:0], 1'b0};
      end
      dlow <= dlow << 1;
      dcnt <= dcnt + 6'd1;
    end
  end

  // Final result: extension rounds toward minus infinity, then clamps.
  logic signed [67:0] qext, rsum;
  logic               sat_hi, sat_lo;

  always_comb begin
    if (mode == REG_MID) begin
      qext = neg ? -$signed({35'd0, quot}) : $signed({35'd0, quot});
    end else if (neg) begin
      qext = -$signed(68'((prod + RND) >> FRAC_BITS));
    end else begin
      qext = $signed(68'(prod >> FRAC_BITS));
    end
    rsum   = 68'(base_y) + qext;
    sat_hi = rsum > 68'sd2147483647;
    sat_lo = rsum < -68'sd2147483648;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      value_out <= sat_hi ? 32'h7FFFFFFF : sat_lo ? 32'h80000000 : rsum[31:0];
      saturated <= sat_hi | sat_lo;
      region    <= mode;
    end
  end

  assign st.hit      = v <= cur_x;
  assign st.first    = idx == '0;
  assign st.last     = idx == last_idx;
  assign st.mul_done = mcnt == 6'(STEPS);
  assign st.div_done = dcnt == 6'(STEPS);
  assign st.interp   = mode == REG_MID;
  assign st.out_busy = out_valid & ~out_ready;

endmodule

// ----- sv/piecewise_linear_lut_core.sv -----
// Piecewise-linear lookup over a table of Q16.16 breakpoints.
// Write items are taken in the idle state. A lookup scans the nodes in order, one node
// table read each, up to the node count, then multiplies, then divides only for a value
// between nodes, then finishes; one lookup at a time.
// Reset (synchronous, active high) clears the node valid bits, so every node reads
// as zero, sets both slopes to 1.0 and the node count to one.
`timescale 1ns / 1ps
module piecewise_linear_lut_core
  import plu_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input item stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // node_index[3:0], node_x[35:4], node_y[67:36],
                                 // value_in[99:68], zero fill[103:100]
  input  logic         s_tuser,  // action
  // Result item stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // value_out
  output logic [2:0]   m_tuser,  // region[1:0], saturated[2]
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic signed [31:0] low_slope, high_slope;
  logic [4:0]         node_count;
  cmd_t               cmd;
  status_t            st;
  region_t            region;
  logic               saturated;

  // The registers are written in the access phase of an APB write.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_slope  <= 32'sd1 <<< FRAC_BITS;
      high_slope <= 32'sd1 <<< FRAC_BITS;
      node_count <= 5'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_LEFT_SLOPE:  low_slope  <= pwdata;
        ADDR_RIGHT_SLOPE: high_slope <= pwdata;
        ADDR_NODE_COUNT:  node_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_LEFT_SLOPE:  prdata = low_slope;
      ADDR_RIGHT_SLOPE: prdata = high_slope;
      ADDR_NODE_COUNT:  prdata = {27'd0, node_count};
      default:          prdata = 32'd0;
    endcase
  end

  // The controller only sequences; the lookup values live in the datapath, the configuration registers in this module.
  plu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .st        (st),
    .cmd       (cmd)
  );

  plu_datapath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .wr_index    (s_tdata[3:0]),
    .wr_x        (s_tdata[35:4]),
    .wr_y        (s_tdata[67:36]),
    .value_in    (s_tdata[99:68]),
    .low_slope   (low_slope),
    .high_slope  (high_slope),
    .node_count  (node_count),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .value_out   (m_tdata),
    .region      (region),
    .saturated   (saturated),
    .st          (st)
  );

  assign m_tuser = {saturated, region};

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for piecewise_linear_lut_core: breakpoint writes and lookups
// against an in-bench predictor, with random bursts, stalls and APB register phases.
// Depends on plu_pkg and the core only.
`timescale 1ns / 1ps
module tb_top
  import plu_pkg::*;
();

  localparam int NODES = 16;
  localparam int FRAC = 16;

  typedef struct packed {
    logic        action;
    logic [3:0]  index;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] value;
  } lut_item_t;

  typedef struct packed {
    logic [31:0] value;
    region_t     region;
    logic        sat;
  } lut_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  piecewise_linear_lut_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The predictor keeps its own breakpoint table and register copies.
  logic signed [31:0] bp_x [NODES];
  logic signed [31:0] bp_y [NODES];
  logic signed [31:0] slope_lo = 32'sh10000;
  logic signed [31:0] slope_hi = 32'sh10000;
  logic [4:0]         nodes_used = 5'd1;

  lut_item_t   pending_items [$];
  lut_result_t expected_results [$];
  int          mismatches = 0;
  bit          hold_sender = 1'b0;

  initial begin
    for (int i = 0; i < NODES; i++) begin
      bp_x[i] = '0;
      bp_y[i] = '0;
    end
  end

  // y + floor(d * s / 2^FRAC), formed at full width; the shift is arithmetic.
  function automatic logic signed [79:0] extend_from(logic signed [31:0] y0,
      logic signed [33:0] d, logic signed [31:0] s);
    logic signed [79:0] prod;
    prod = 80'(d) * 80'(s);
    return 80'(y0) + (prod >>> FRAC);
  endfunction

  function automatic lut_result_t map_value(logic signed [31:0] v);
    lut_result_t res;
    logic signed [79:0] r;
    logic signed [33:0] dx, dy, dv;
    logic [79:0] q;
    int n;
    bit found;
    n = (nodes_used == 0) ? 1 : (nodes_used > NODES ? NODES : nodes_used);
    found = 1'b0;
    r = '0;
    res.region = REG_LEFT;
    if (v <= bp_x[0]) begin
      r = extend_from(bp_y[0], 34'(v) - 34'(bp_x[0]), slope_lo);
      found = 1'b1;
    end
    for (int i = 1; i < n && !found; i++) begin
      if (v <= bp_x[i]) begin
        dx = 34'(bp_x[i]) - 34'(bp_x[i-1]);
        dy = 34'(bp_y[i]) - 34'(bp_y[i-1]);
        dv = 34'(v) - 34'(bp_x[i-1]);
        q = (80'(dv) * 80'(dy < 0 ? -dy : dy)) / 80'(dx);
        r = (dy < 0) ? 80'(bp_y[i-1]) - $signed(q) : 80'(bp_y[i-1]) + $signed(q);
        res.region = REG_MID;
        found = 1'b1;
      end
    end
    if (!found) begin
      r = extend_from(bp_y[n-1], 34'(v) - 34'(bp_x[n-1]), slope_hi);
      res.region = REG_RIGHT;
    end
    res.sat = 1'b0;
    if (r > 80'sh7fffffff) begin
      r = 80'sh7fffffff;
      res.sat = 1'b1;
    end else if (r < -80'sh80000000) begin
      r = -80'sh80000000;
      res.sat = 1'b1;
    end
    res.value = r[31:0];
    return res;
  endfunction

  // Predict at the accepting edge so that table updates track the block exactly.
  task automatic predict_item(lut_item_t it);
    if (it.action == ACT_WRITE) begin
      bp_x[it.index] = it.x;
      bp_y[it.index] = it.y;
    end else begin
      expected_results.push_back(map_value(it.value));
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_item(lut_item_t'({s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[67:36],
                                  s_tdata[99:68]}));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || hold_sender || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else begin
          automatic lut_item_t it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.action;
          s_tdata  <= {4'b0, it.value, it.y, it.x, it.index};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall pattern from a rotating mask, occasionally reshuffled.
  logic [15:0] stall_mask = 16'h0000;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 200) == 0)
        stall_mask <= ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
      else
        stall_mask <= {stall_mask[14:0], stall_mask[15]};
      m_tready <= !stall_mask[0];
    end
  end

  // Monitor: every accepted result goes against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result item: value %h user %b", m_tdata, m_tuser);
      end else begin
        automatic lut_result_t e = expected_results.pop_front();
        if (m_tdata !== e.value || m_tuser[1:0] !== e.region || m_tuser[2] !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected value %h region %0d sat %b, got %h %0d %b",
                     e.value, e.region, e.sat, m_tdata, m_tuser[1:0], m_tuser[2]);
        end
      end
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_LEFT_SLOPE) slope_lo = data;
    else if (addr == ADDR_RIGHT_SLOPE) slope_hi = data;
    else if (addr == ADDR_NODE_COUNT) nodes_used = data[4:0];
  endtask

  // Wait for the queue and the block to drain; a write item leaves no result to wait on.
  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic lut_item_t write_item(int idx, logic [31:0] x, logic [31:0] y);
    lut_item_t it;
    it = '0;
    it.action = ACT_WRITE;
    it.index = 4'(idx);
    it.x = x;
    it.y = y;
    it.value = $urandom;
    return it;
  endfunction

  function automatic lut_item_t lookup_item(logic [31:0] v);
    lut_item_t it;
    it = '0;
    it.action = ACT_LOOKUP;
    it.index = 4'($urandom);
    it.x = $urandom;
    it.y = $urandom;
    it.value = v;
    return it;
  endfunction

  // Picks a lookup value near the table, at or next to a node, at either extreme, or anywhere in the range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return bp_x[$urandom_range(0, NODES - 1)];
      2: return bp_x[$urandom_range(0, NODES - 1)] + $urandom_range(0, 2) - 1;
      3: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000) <<< 6;
    endcase
  endfunction

  // Fills the table with sorted breakpoints of random spacing (sometimes unsorted).
  task automatic load_table(bit sorted);
    logic signed [31:0] x;
    x = -$signed(32'($urandom_range(0, 32'h7000000))) <<< 2;
    for (int i = 0; i < NODES; i++) begin
      if (sorted) x = x + $urandom_range(0, 32'h1000000);
      else x = $urandom;
      pending_items.push_back(write_item(i, x, ($urandom_range(0, 3) == 0) ? $urandom
                                               : 32'($signed($urandom_range(0, 32'hfffff))
                                                 - 32'sh80000) <<< 4));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: the cleared table, extremes at default slopes, interpolation corners.
    pending_items.push_back(lookup_item(32'h0));
    pending_items.push_back(lookup_item(32'h7fffffff));
    pending_items.push_back(lookup_item(32'h80000000));
    pending_items.push_back(write_item(0, 32'h80000000, 32'h7fffffff));
    pending_items.push_back(write_item(1, 32'h7fffffff, 32'h80000000));
    pending_items.push_back(write_item(15, 32'h00010000, 32'hffff0000));
    drain();
    reg_write(ADDR_NODE_COUNT, 32'd2);
    reg_write(ADDR_LEFT_SLOPE, 32'h7fffffff);
    reg_write(ADDR_RIGHT_SLOPE, 32'h80000000);
    pending_items.push_back(lookup_item(32'h80000000));
    pending_items.push_back(lookup_item(32'h80000001));
    pending_items.push_back(lookup_item(32'h00000000));
    pending_items.push_back(lookup_item(32'h7fffffff));
    pending_items.push_back(write_item(1, 32'h00000000, 32'h00000000));
    pending_items.push_back(lookup_item(32'h00000001));
    drain();
    // Count of zero and count above the table size.
    reg_write(ADDR_NODE_COUNT, 32'd0);
    pending_items.push_back(lookup_item(32'h00000005));
    drain();
    reg_write(ADDR_NODE_COUNT, 32'd31);
    pending_items.push_back(lookup_item(32'h7fffffff));
    pending_items.push_back(lookup_item(32'h00008000));
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: reg_write(ADDR_LEFT_SLOPE, 32'h80000000);
        1: reg_write(ADDR_LEFT_SLOPE, $urandom);
        2: reg_write(ADDR_LEFT_SLOPE, 32'h00010000);
        default: reg_write(ADDR_LEFT_SLOPE, 32'h7fffffff);
      endcase
      reg_write(ADDR_RIGHT_SLOPE, (phase % 3 == 0) ? 32'h7fffffff : $urandom);
      reg_write(ADDR_NODE_COUNT, (phase == 3) ? 32'd16 : (phase == 7) ? 32'd1
                                 : $urandom_range(0, 31));
      load_table(phase != 5);
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) == 0)
          pending_items.push_back(write_item($urandom_range(0, 15), $urandom, $urandom));
        else
          pending_items.push_back(lookup_item(pick_value()));
      end
      // One phase pauses the sender until everything in flight has come back.
      if (phase == 6) begin
        hold_sender = 1'b1;
        while (expected_results.size() != 0 || s_tvalid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Worst case is well under 1000 items plus stalls.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/plu_pkg.sv
sv/plu_ram.sv
sv/plu_ctrl.sv
sv/plu_datapath.sv
sv/piecewise_linear_lut_core.sv
bench/tb_top.sv
